// File: hdl/nrot_pkg.sv
`default_nettype none

package nrot_pkg;

    // Default coordinate width of the edge vector and rotation pair.
    localparam int COORD_WIDTH_DEF = 16;

    // Default number of fraction bits of the normalized rotation pair.
    localparam int INNER_FRAC_DEF = 18;

    // Width of the rotated coordinates on the output word.
    localparam int OUT_W = 17;

    // Saturation bounds of the rotated coordinates, as magnitudes.
    localparam logic [OUT_W-1:0] OUT_POS_MAX = 17'h0FFFF;
    localparam logic [OUT_W-1:0] OUT_NEG_MAX = 17'h10000;

endpackage : nrot_pkg

`default_nettype wire

// File: hdl/nrot_prep.sv
`default_nettype none

module nrot_prep
    import nrot_pkg::*;
#(
    parameter int CW = COORD_WIDTH_DEF,
    parameter int F = INNER_FRAC_DEF,
    localparam int SQ_W = 2*CW - 1,
    localparam int N_W = 2*CW,
    localparam int REM_W = 2*CW + 2*F + 2,
    localparam int NT_W = 2*CW + F + 3
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       up_valid,
    output logic                            up_ready,
    input  wire logic [CW-1:0]              x_in,
    input  wire logic [CW-1:0]              y_in,
    input  wire logic [CW-1:0]              c_in,
    input  wire logic [CW-1:0]              s_in,
    input  wire logic                       dn_ready,
    output logic                            dn_valid,
    output logic [CW-1:0]                   x_out,
    output logic [CW-1:0]                   y_out,
    output logic                            cneg_out,
    output logic                            sneg_out,
    output logic                            degen_out,
    output logic [N_W-1:0]                  n_out,
    output logic [1:0][REM_W-1:0]           rem_out,
    output logic [1:0][NT_W-1:0]            nt_out
);

    // Stage one: magnitudes and squares of the rotation pair.
    logic              v1_reg;
    logic              rdy1;
    logic [CW-1:0]     x1_reg;
    logic [CW-1:0]     y1_reg;
    logic              cneg1_reg;
    logic              sneg1_reg;
    logic [SQ_W-1:0]   c2_reg;
    logic [SQ_W-1:0]   s2_reg;
    logic [CW-1:0]     c_mag;
    logic [CW-1:0]     s_mag;
    logic [2*CW-1:0]   c_prod;
    logic [2*CW-1:0]   s_prod;
    logic [SQ_W-1:0]   c2_next;
    logic [SQ_W-1:0]   s2_next;

    // Stage two: squared length and initial remainders.
    logic              v2_reg;
    logic              rdy2;
    logic [N_W-1:0]    n_sum;
    logic [REM_W-1:0]  c_shift;
    logic [REM_W-1:0]  s_shift;
    logic [REM_W-1:0]  n_ext;
    logic [REM_W-1:0]  remc_next;
    logic [REM_W-1:0]  rems_next;
    logic [NT_W-1:0]   nt_next;
    logic [CW-1:0]     x2_reg;
    logic [CW-1:0]     y2_reg;
    logic              cneg2_reg;
    logic              sneg2_reg;
    logic              degen2_reg;
    logic [N_W-1:0]    n2_reg;
    logic [REM_W-1:0]  remc_reg;
    logic [REM_W-1:0]  rems_reg;
    logic [NT_W-1:0]   nt_reg;

    // A stage takes a new word when it is empty or its word moves on.
    assign rdy2 = !v2_reg || dn_ready;
    assign rdy1 = !v1_reg || rdy2;
    assign up_ready = rdy1;

    // Magnitudes; the most negative code maps onto its unsigned magnitude.
    assign c_mag = c_in[CW-1] ? (~c_in + 1'b1) : c_in;
    assign s_mag = s_in[CW-1] ? (~s_in + 1'b1) : s_in;
    assign c_prod = c_mag * c_mag;
    assign s_prod = s_mag * s_mag;
    assign c2_next = c_prod[SQ_W-1:0];
    assign s2_next = s_prod[SQ_W-1:0];

    // The remainder starts at v^2 * 2^(2F+2) - n, which is the test value
    // for a normalized magnitude of zero.
    assign n_sum = {1'b0, c2_reg} + {1'b0, s2_reg};
    assign c_shift = {1'b0, c2_reg, {(2*F + 2){1'b0}}};
    assign s_shift = {1'b0, s2_reg, {(2*F + 2){1'b0}}};
    assign n_ext = {{(REM_W - N_W){1'b0}}, n_sum};
    assign remc_next = c_shift - n_ext;
    assign rems_next = s_shift - n_ext;
    assign nt_next = {NT_W{1'b0}} - {{(NT_W - N_W){1'b0}}, n_sum};

    // Valid bits of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= up_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    // Payload of stage one.
    always_ff @(posedge clk)
    begin
        if (up_valid && rdy1)
        begin
            x1_reg    <= x_in;
            y1_reg    <= y_in;
            cneg1_reg <= c_in[CW-1];
            sneg1_reg <= s_in[CW-1];
            c2_reg    <= c2_next;
            s2_reg    <= s2_next;
        end
    end

    // Payload of stage two.
    always_ff @(posedge clk)
    begin
        if (v1_reg && rdy2)
        begin
            x2_reg     <= x1_reg;
            y2_reg     <= y1_reg;
            cneg2_reg  <= cneg1_reg;
            sneg2_reg  <= sneg1_reg;
            degen2_reg <= (n_sum == '0);
            n2_reg     <= n_sum;
            remc_reg   <= remc_next;
            rems_reg   <= rems_next;
            nt_reg     <= nt_next;
        end
    end

    assign dn_valid   = v2_reg;
    assign x_out      = x2_reg;
    assign y_out      = y2_reg;
    assign cneg_out   = cneg2_reg;
    assign sneg_out   = sneg2_reg;
    assign degen_out  = degen2_reg;
    assign n_out      = n2_reg;
    assign rem_out[0] = remc_reg;
    assign rem_out[1] = rems_reg;
    assign nt_out[0]  = nt_reg;
    assign nt_out[1]  = nt_reg;

endmodule : nrot_prep

`default_nettype wire

// File: hdl/nrot_cell.sv
`default_nettype none

module nrot_cell
    import nrot_pkg::*;
#(
    parameter int CW = COORD_WIDTH_DEF,
    parameter int F = INNER_FRAC_DEF,
    parameter int BIT = 0,
    localparam int N_W = 2*CW,
    localparam int REM_W = 2*CW + 2*F + 2,
    localparam int NT_W = 2*CW + F + 3,
    localparam int M_W = F + 1,
    localparam int D_W = 2*CW + 2*F + 6
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       up_valid,
    output logic                            up_ready,
    input  wire logic [CW-1:0]              x_in,
    input  wire logic [CW-1:0]              y_in,
    input  wire logic                       cneg_in,
    input  wire logic                       sneg_in,
    input  wire logic                       degen_in,
    input  wire logic [N_W-1:0]             n_in,
    input  wire logic [1:0][REM_W-1:0]      rem_in,
    input  wire logic [1:0][NT_W-1:0]       nt_in,
    input  wire logic [1:0][M_W-1:0]        m_in,
    input  wire logic                       dn_ready,
    output logic                            dn_valid,
    output logic [CW-1:0]                   x_out,
    output logic [CW-1:0]                   y_out,
    output logic                            cneg_out,
    output logic                            sneg_out,
    output logic                            degen_out,
    output logic [N_W-1:0]                  n_out,
    output logic [1:0][REM_W-1:0]           rem_out,
    output logic [1:0][NT_W-1:0]            nt_out,
    output logic [1:0][M_W-1:0]             m_out
);

    logic                  valid_reg;
    logic [CW-1:0]         x_reg;
    logic [CW-1:0]         y_reg;
    logic                  cneg_reg;
    logic                  sneg_reg;
    logic                  degen_reg;
    logic [N_W-1:0]        n_reg;
    logic [1:0][REM_W-1:0] rem_reg;
    logic [1:0][NT_W-1:0]  nt_reg;
    logic [1:0][M_W-1:0]   m_reg;
    logic [1:0][REM_W-1:0] rem_next;
    logic [1:0][NT_W-1:0]  nt_next;
    logic [1:0][M_W-1:0]   m_next;

    assign up_ready = !valid_reg || dn_ready;

    // Each lane decides one bit of its normalized magnitude m. With t = 2m - 1,
    // the remainder holds v^2 * 2^(2F+2) - t^2 * n and nt holds t * n. Setting
    // bit BIT raises t by d = 2^(BIT+1), which lowers the remainder by
    // 2*d*t*n + d^2*n; the bit stays when the remainder does not go negative.
    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        logic signed [D_W-1:0] rem_ext;
        logic signed [D_W-1:0] nt_sh;
        logic signed [D_W-1:0] n_sh;
        logic signed [D_W-1:0] trial;
        logic                  take;

        assign rem_ext = D_W'($signed(rem_in[l]));
        assign nt_sh   = D_W'($signed(nt_in[l])) <<< (BIT + 2);
        assign n_sh    = $signed({{(D_W - N_W){1'b0}}, n_in}) <<< (2*BIT + 2);
        assign trial   = rem_ext - nt_sh - n_sh;
        assign take    = !trial[D_W-1];

        assign rem_next[l] = take ? trial[REM_W-1:0] : rem_in[l];
        assign nt_next[l]  = take ? (nt_in[l] + (NT_W'(n_in) << (BIT + 1))) : nt_in[l];
        assign m_next[l]   = take ? (m_in[l] | (M_W'(1) << BIT)) : m_in[l];
    end

    // Valid bit of the cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    // Payload of the cell.
    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            x_reg     <= x_in;
            y_reg     <= y_in;
            cneg_reg  <= cneg_in;
            sneg_reg  <= sneg_in;
            degen_reg <= degen_in;
            n_reg     <= n_in;
            rem_reg   <= rem_next;
            nt_reg    <= nt_next;
            m_reg     <= m_next;
        end
    end

    assign dn_valid  = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign cneg_out  = cneg_reg;
    assign sneg_out  = sneg_reg;
    assign degen_out = degen_reg;
    assign n_out     = n_reg;
    assign rem_out   = rem_reg;
    assign nt_out    = nt_reg;
    assign m_out     = m_reg;

endmodule : nrot_cell

`default_nettype wire

// File: hdl/nrot_out.sv
`default_nettype none

module nrot_out
    import nrot_pkg::*;
#(
    parameter int CW = COORD_WIDTH_DEF,
    parameter int F = INNER_FRAC_DEF,
    localparam int M_W = F + 1,
    localparam int P_W = F + CW + 2,
    localparam int A_W = F + CW + 3,
    localparam int R_W = A_W + 1 - F,
    localparam int X_W = R_W + OUT_W
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       up_valid,
    output logic                            up_ready,
    input  wire logic [CW-1:0]              x_in,
    input  wire logic [CW-1:0]              y_in,
    input  wire logic                       cneg_in,
    input  wire logic                       sneg_in,
    input  wire logic                       degen_in,
    input  wire logic [1:0][M_W-1:0]        m_in,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [OUT_W-1:0]                out_x,
    output logic [OUT_W-1:0]                out_y,
    output logic                            degenerate
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    // Stage one: signed unit pair times the edge vector.
    logic signed [F+1:0] cn;
    logic signed [F+1:0] sn;
    logic signed [P_W-1:0] pxc_next, pys_next, pyc_next, pxs_next;
    logic signed [P_W-1:0] pxc_reg, pys_reg, pyc_reg, pxs_reg;
    logic dg1_reg;

    // Stage two: rotated sums, exact.
    logic signed [A_W-1:0] accx_next, accy_next;
    logic signed [A_W-1:0] accx_reg, accy_reg;
    logic dg2_reg;

    // Stage three: magnitudes rounded half away from zero.
    logic [A_W-1:0] magx, magy;
    logic [A_W:0]   sumx, sumy;
    logic [R_W-1:0] rx_reg, ry_reg;
    logic           negx_reg, negy_reg;
    logic           dg3_reg;

    // Stage four: saturation, sign and the output register.
    logic [X_W-1:0]   rx_ext, ry_ext;
    logic [X_W-1:0]   limx, limy;
    logic [X_W-1:0]   satx, saty;
    logic [X_W-1:0]   sgnx, sgny;
    logic [OUT_W-1:0] outx_next, outy_next;
    logic [OUT_W-1:0] outx_reg, outy_reg;
    logic             dg4_reg;

    // The last stage frees up as soon as its word is taken.
    assign rdy4 = !v4_reg || !out_stall;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign up_ready = rdy1;

    assign cn = cneg_in ? -$signed({1'b0, m_in[0]}) : $signed({1'b0, m_in[0]});
    assign sn = sneg_in ? -$signed({1'b0, m_in[1]}) : $signed({1'b0, m_in[1]});
    assign pxc_next = cn * $signed(x_in);
    assign pys_next = sn * $signed(y_in);
    assign pyc_next = cn * $signed(y_in);
    assign pxs_next = sn * $signed(x_in);

    assign accx_next = pxc_reg + pys_reg;
    assign accy_next = pyc_reg - pxs_reg;

    assign magx = accx_reg[A_W-1] ? (~accx_reg + 1'b1) : accx_reg;
    assign magy = accy_reg[A_W-1] ? (~accy_reg + 1'b1) : accy_reg;
    assign sumx = {1'b0, magx} + ((A_W+1)'(1) << (F - 1));
    assign sumy = {1'b0, magy} + ((A_W+1)'(1) << (F - 1));

    // Clamp to the output range, then apply the sign.
    assign rx_ext = X_W'(rx_reg);
    assign ry_ext = X_W'(ry_reg);
    assign limx = negx_reg ? X_W'(OUT_NEG_MAX) : X_W'(OUT_POS_MAX);
    assign limy = negy_reg ? X_W'(OUT_NEG_MAX) : X_W'(OUT_POS_MAX);
    assign satx = (rx_ext > limx) ? limx : rx_ext;
    assign saty = (ry_ext > limy) ? limy : ry_ext;
    assign sgnx = negx_reg ? ({X_W{1'b0}} - satx) : satx;
    assign sgny = negy_reg ? ({X_W{1'b0}} - saty) : saty;
    assign outx_next = dg3_reg ? '0 : sgnx[OUT_W-1:0];
    assign outy_next = dg3_reg ? '0 : sgny[OUT_W-1:0];

    // Valid bits of the four stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= up_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // Payload of the four stages.
    always_ff @(posedge clk)
    begin
        if (up_valid && rdy1)
        begin
            pxc_reg <= pxc_next;
            pys_reg <= pys_next;
            pyc_reg <= pyc_next;
            pxs_reg <= pxs_next;
            dg1_reg <= degen_in;
        end
        if (v1_reg && rdy2)
        begin
            accx_reg <= accx_next;
            accy_reg <= accy_next;
            dg2_reg  <= dg1_reg;
        end
        if (v2_reg && rdy3)
        begin
            rx_reg   <= sumx[A_W:F];
            ry_reg   <= sumy[A_W:F];
            negx_reg <= accx_reg[A_W-1];
            negy_reg <= accy_reg[A_W-1];
            dg3_reg  <= dg2_reg;
        end
        if (v3_reg && rdy4)
        begin
            outx_reg <= outx_next;
            outy_reg <= outy_next;
            dg4_reg  <= dg3_reg;
        end
    end

    assign out_valid  = v4_reg;
    assign out_x      = outx_reg;
    assign out_y      = outy_reg;
    assign degenerate = dg4_reg;

endmodule : nrot_out

`default_nettype wire

// File: hdl/normalized_2d_rotation.sv
// Normalized 2-D rotation of an edge vector.
//
// Input channel: in_valid / in_stall with edge_x, edge_y, rot_c and rot_s. A word
// is taken at a rising edge with in_valid high and in_stall low. Output channel:
// out_valid / out_stall with out_x, out_y and degenerate, taken the same way.
//
// The pair (rot_c, rot_s) is scaled to unit length with INNER_FRAC_BITS fraction
// bits by a row of INNER_FRAC_BITS + 1 cells, one bit of each normalized value per
// cell, and the edge vector is then rotated and rounded to the nearest integer.
// A zero pair gives zero coordinates with degenerate set.
//
// The pipeline has two setup stages, the cell row and four output stages.
// Throughput is one word per cycle while the receiver does not stall.
// Every stage keeps its own valid bit, so a stalled receiver only holds the
// words that queue up behind the output register; in_stall rises only once
// the whole pipeline is full. Reset empties the pipeline and drops any word
// in flight; no clearing pass is needed.
`default_nettype none

module normalized_2d_rotation
    import nrot_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int INNER_FRAC_BITS = INNER_FRAC_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [COORD_WIDTH-1:0] edge_x,
    input  wire logic signed [COORD_WIDTH-1:0] edge_y,
    input  wire logic signed [COORD_WIDTH-1:0] rot_c,
    input  wire logic signed [COORD_WIDTH-1:0] rot_s,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [OUT_W-1:0]            out_x,
    output logic signed [OUT_W-1:0]            out_y,
    output logic                               degenerate
);

    localparam int CW = COORD_WIDTH;
    localparam int F = INNER_FRAC_BITS;
    localparam int NCELL = F + 1;
    localparam int N_W = 2*CW;
    localparam int REM_W = 2*CW + 2*F + 2;
    localparam int NT_W = 2*CW + F + 3;
    localparam int M_W = F + 1;

    // Links of the cell row; link 0 comes from the setup stages.
    logic                  ch_valid [NCELL+1];
    logic                  ch_ready [NCELL+1];
    logic [CW-1:0]         ch_x     [NCELL+1];
    logic [CW-1:0]         ch_y     [NCELL+1];
    logic                  ch_cneg  [NCELL+1];
    logic                  ch_sneg  [NCELL+1];
    logic                  ch_degen [NCELL+1];
    logic [N_W-1:0]        ch_n     [NCELL+1];
    logic [1:0][REM_W-1:0] ch_rem   [NCELL+1];
    logic [1:0][NT_W-1:0]  ch_nt    [NCELL+1];
    logic [1:0][M_W-1:0]   ch_m     [NCELL+1];
    logic                  prep_ready;
    logic [OUT_W-1:0]      ox;
    logic [OUT_W-1:0]      oy;

    assign in_stall = !prep_ready;
    assign ch_m[0]  = '0;

    // Squares of the pair and the initial remainders.
    nrot_prep #(
        .CW (CW),
        .F  (F)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (in_valid),
        .up_ready  (prep_ready),
        .x_in      (edge_x),
        .y_in      (edge_y),
        .c_in      (rot_c),
        .s_in      (rot_s),
        .dn_ready  (ch_ready[0]),
        .dn_valid  (ch_valid[0]),
        .x_out     (ch_x[0]),
        .y_out     (ch_y[0]),
        .cneg_out  (ch_cneg[0]),
        .sneg_out  (ch_sneg[0]),
        .degen_out (ch_degen[0]),
        .n_out     (ch_n[0]),
        .rem_out   (ch_rem[0]),
        .nt_out    (ch_nt[0])
    );

    // Row of cells, most significant bit first.
    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        nrot_cell #(
            .CW  (CW),
            .F   (F),
            .BIT (F - i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .up_valid  (ch_valid[i]),
            .up_ready  (ch_ready[i]),
            .x_in      (ch_x[i]),
            .y_in      (ch_y[i]),
            .cneg_in   (ch_cneg[i]),
            .sneg_in   (ch_sneg[i]),
            .degen_in  (ch_degen[i]),
            .n_in      (ch_n[i]),
            .rem_in    (ch_rem[i]),
            .nt_in     (ch_nt[i]),
            .m_in      (ch_m[i]),
            .dn_ready  (ch_ready[i+1]),
            .dn_valid  (ch_valid[i+1]),
            .x_out     (ch_x[i+1]),
            .y_out     (ch_y[i+1]),
            .cneg_out  (ch_cneg[i+1]),
            .sneg_out  (ch_sneg[i+1]),
            .degen_out (ch_degen[i+1]),
            .n_out     (ch_n[i+1]),
            .rem_out   (ch_rem[i+1]),
            .nt_out    (ch_nt[i+1]),
            .m_out     (ch_m[i+1])
        );
    end

    // Rotation, rounding and the output register.
    nrot_out #(
        .CW (CW),
        .F  (F)
    ) u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (ch_valid[NCELL]),
        .up_ready   (ch_ready[NCELL]),
        .x_in       (ch_x[NCELL]),
        .y_in       (ch_y[NCELL]),
        .cneg_in    (ch_cneg[NCELL]),
        .sneg_in    (ch_sneg[NCELL]),
        .degen_in   (ch_degen[NCELL]),
        .m_in       (ch_m[NCELL]),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_x      (ox),
        .out_y      (oy),
        .degenerate (degenerate)
    );

    assign out_x = $signed(ox);
    assign out_y = $signed(oy);

    // A degenerate word carries zero coordinates.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && degenerate) |-> (out_x == '0 && out_y == '0))
        else $error("degenerate word with nonzero coordinates");

    // With the output register empty, no stage can be holding up the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while the output register is empty");

    // The n and remainder of the last link feed nothing beyond the row; the
    // check below keeps the n link consistent with the degenerate flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        ch_valid[NCELL] |-> (ch_degen[NCELL] == (ch_n[NCELL] == '0)))
        else $error("degenerate flag disagrees with the squared length");

endmodule : normalized_2d_rotation

`default_nettype wire

// File: bench/normalized_2d_rotation_test.sv
`timescale 1ns / 100ps

module normalized_2d_rotation_test;

    import nrot_pkg::*;

    localparam int CW = COORD_WIDTH_DEF;
    localparam int FRAC = INNER_FRAC_DEF;
    localparam int RANDOM_WORDS = 1200;
    localparam int HOLD_AT = 400;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT = 200000;

    // One rotated word as it leaves the block.
    typedef struct packed {
        logic [OUT_W-1:0] x;
        logic [OUT_W-1:0] y;
        logic             deg;
    } rot_result_t;

    // One row of the directed table; want is used only where known is set.
    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] c;
        logic signed [CW-1:0] s;
        bit                   known;
        rot_result_t          want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [CW-1:0] edge_x = '0;
    logic signed [CW-1:0] edge_y = '0;
    logic signed [CW-1:0] rot_c = '0;
    logic signed [CW-1:0] rot_s = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [OUT_W-1:0] out_x;
    logic signed [OUT_W-1:0] out_y;
    logic degenerate;

    rot_result_t rotated_q[$];
    int mismatch_count = 0;
    int burst_left = 0;
    logic hold_req = 1'b0;
    logic hold_done;
    int hold_left;
    int pace_mode;
    int pace_left;
    int cycles;

    // Identity, axis, degenerate and full-scale cases come first.
    stim_row_t directed_rows [18] = '{
        '{16'sd1234, -16'sd567, 16'sd1, 16'sd0, 1'b1, '{17'sd1234, -17'sd567, 1'b0}},
        '{16'sd32767, -16'sd32768, 16'sd0, 16'sd0, 1'b1, '{17'sd0, 17'sd0, 1'b1}},
        '{16'sd32767, -16'sd32768, -16'sd32768, 16'sd0, 1'b1,
          '{-17'sd32767, 17'sd32768, 1'b0}},
        '{-16'sd32768, 16'sd32767, 16'sd0, 16'sd1, 1'b1, '{17'sd32767, 17'sd32768, 1'b0}},
        '{16'sd100, -16'sd200, 16'sd0, -16'sd32768, 1'b1, '{17'sd200, 17'sd100, 1'b0}},
        '{16'sd0, 16'sd0, 16'sd5, 16'sd7, 1'b1, '{17'sd0, 17'sd0, 1'b0}},
        '{-16'sd32768, -16'sd32768, 16'sd0, 16'sd0, 1'b1, '{17'sd0, 17'sd0, 1'b1}},
        '{16'sd0, 16'sd32767, 16'sd32767, 16'sd0, 1'b1, '{17'sd0, 17'sd32767, 1'b0}},
        '{16'sd1, -16'sd1, 16'sd2, 16'sd0, 1'b1, '{17'sd1, -17'sd1, 1'b0}},
        '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0, '{'0, '0, 1'b0}},
        '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0, '{'0, '0, 1'b0}},
        '{-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, 1'b0, '{'0, '0, 1'b0}},
        '{16'sd3, 16'sd4, 16'sd3, 16'sd4, 1'b0, '{'0, '0, 1'b0}},
        '{16'sd1000, 16'sd0, 16'sd3, -16'sd4, 1'b0, '{'0, '0, 1'b0}},
        '{-16'sd1, -16'sd1, -16'sd1, -16'sd1, 1'b0, '{'0, '0, 1'b0}},
        '{16'sd32767, 16'sd0, 16'sd1, 16'sd32767, 1'b0, '{'0, '0, 1'b0}},
        '{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd1, 1'b0, '{'0, '0, 1'b0}},
        '{16'sd12345, -16'sd23456, 16'sd17, -16'sd29, 1'b0, '{'0, '0, 1'b0}}
    };

    normalized_2d_rotation u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .edge_x     (edge_x),
        .edge_y     (edge_y),
        .rot_c      (rot_c),
        .rot_s      (rot_s),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_x      (out_x),
        .out_y      (out_y),
        .degenerate (degenerate)
    );

    always #5 clk = ~clk;

    // Largest m with (2m-1)^2 * norm2 <= 4 * sq * 2^(2*FRAC), which is
    // sqrt(sq / norm2) scaled by 2^FRAC and rounded with ties away from zero.
    function automatic longint unsigned unit_component(longint unsigned sq,
                                                       longint unsigned norm2);
        logic [127:0] bound;
        logic [127:0] lhs;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned odd;
        bound = {64'd0, sq} << (2 * FRAC + 2);
        lo = 0;
        hi = 64'd1 << FRAC;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >> 1;
            odd = 2 * mid - 1;
            lhs = {64'd0, odd * odd} * {64'd0, norm2};
            if (lhs <= bound)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    // Drop the fraction bits with round-half-away and clamp to the output range.
    function automatic logic [OUT_W-1:0] round_coord(longint signed acc);
        longint unsigned mag;
        longint unsigned r;
        mag = (acc < 0) ? longint'(-acc) : longint'(acc);
        r = (mag + (64'd1 << (FRAC - 1))) >> FRAC;
        if (acc < 0)
        begin
            if (r > OUT_NEG_MAX)
                r = OUT_NEG_MAX;
            return OUT_W'(64'd0 - r);
        end
        if (r > OUT_POS_MAX)
            r = OUT_POS_MAX;
        return OUT_W'(r);
    endfunction

    // Normalize the rotation pair and rotate the edge vector by it.
    function automatic rot_result_t rotate_edge(logic signed [CW-1:0] x,
                                                logic signed [CW-1:0] y,
                                                logic signed [CW-1:0] c,
                                                logic signed [CW-1:0] s);
        rot_result_t res;
        longint unsigned c2;
        longint unsigned s2;
        longint unsigned norm2;
        longint signed cn;
        longint signed sn;
        longint signed xl;
        longint signed yl;
        c2 = longint'(c) * longint'(c);
        s2 = longint'(s) * longint'(s);
        norm2 = c2 + s2;
        res = '0;
        if (norm2 == 0)
        begin
            res.deg = 1'b1;
            return res;
        end
        cn = longint'(unit_component(c2, norm2));
        sn = longint'(unit_component(s2, norm2));
        if (c < 0)
            cn = -cn;
        if (s < 0)
            sn = -sn;
        xl = longint'(x);
        yl = longint'(y);
        res.x = round_coord(cn * xl + sn * yl);
        res.y = round_coord(cn * yl - sn * xl);
        return res;
    endfunction

    // Field values biased toward the extremes and toward small magnitudes.
    function automatic logic signed [CW-1:0] pick_coord();
        logic signed [CW-1:0] v;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 5))
                    0: v = -16'sd32768;
                    1: v = -16'sd32767;
                    2: v = -16'sd1;
                    3: v = 16'sd0;
                    4: v = 16'sd1;
                    default: v = 16'sd32767;
                endcase
            end
            1: v = CW'($urandom_range(0, 16)) - CW'(8);
            default: v = CW'($urandom());
        endcase
        return v;
    endfunction

    // Offer one word, wait for it to be taken, then maybe pause between bursts.
    task automatic offer_word(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                              logic signed [CW-1:0] c, logic signed [CW-1:0] s,
                              bit known, rot_result_t known_want);
        edge_x <= x;
        edge_y <= y;
        rot_c <= c;
        rot_s <= s;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        rotated_q.push_back(known ? known_want : rotate_edge(x, y, c, s));
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 48);
        end
        else
            burst_left--;
    endtask

    // Receiver pacing: random stall patterns, plus one long hold-off on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_done <= 1'b0;
            hold_left <= 0;
            pace_mode <= 0;
            pace_left <= 0;
        end
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_done)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
        begin
            if (pace_left == 0)
            begin
                pace_mode <= $urandom_range(0, 3);
                pace_left <= $urandom_range(4, 60);
            end
            else
                pace_left <= pace_left - 1;
            case (pace_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 1) == 1);
                default: out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Compare every word taken from the output with the oldest expectation.
    always @(posedge clk)
    begin
        rot_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (rotated_q.size() == 0)
            begin
                $error("unexpected output word: out_x %0d out_y %0d degenerate %0b",
                       out_x, out_y, degenerate);
                mismatch_count++;
            end
            else
            begin
                want = rotated_q.pop_front();
                if (out_x !== want.x)
                begin
                    $error("out_x: expected %0d, actual %0d", $signed(want.x), out_x);
                    mismatch_count++;
                end
                if (out_y !== want.y)
                begin
                    $error("out_y: expected %0d, actual %0d", $signed(want.y), out_y);
                    mismatch_count++;
                end
                if (degenerate !== want.deg)
                begin
                    $error("degenerate: expected %0b, actual %0b", want.deg, degenerate);
                    mismatch_count++;
                end
            end
        end
    end

    // Guard against a hung handshake.
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // Stimulus: directed table, then random words with one long output hold-off.
    initial
    begin
        logic signed [CW-1:0] rx;
        logic signed [CW-1:0] ry;
        logic signed [CW-1:0] rc;
        logic signed [CW-1:0] rs;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        burst_left = $urandom_range(1, 48);

        foreach (directed_rows[i])
            offer_word(directed_rows[i].x, directed_rows[i].y, directed_rows[i].c,
                       directed_rows[i].s, directed_rows[i].known, directed_rows[i].want);

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            // Keep offering without gaps while the receiver holds off.
            if (n == HOLD_AT)
            begin
                hold_req <= 1'b1;
                burst_left = 200;
            end
            rx = pick_coord();
            ry = pick_coord();
            case ($urandom_range(0, 19))
                0:
                begin
                    rc = '0;
                    rs = '0;
                end
                1:
                begin
                    rc = '0;
                    rs = pick_coord();
                end
                2:
                begin
                    rc = pick_coord();
                    rs = '0;
                end
                default:
                begin
                    rc = pick_coord();
                    rs = pick_coord();
                end
            endcase
            offer_word(rx, ry, rc, rs, 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (rotated_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
